// ===== hw/rtl/ihcs_pkg.sv =====
// Package for the IPv4 header classifier: beat types, codes, counter type
// and the small classification functions. No dependencies.
package ihcs_pkg;

   localparam int COUNTER_WIDTH     = 32;
   localparam int NUM_COUNTERS      = 12;
   localparam int NUM_PROTO_CLASSES = 7;
   localparam int BIN_BASE          = 7;
   localparam int NUM_BINS          = 5;
   localparam int JOB_DEPTH         = 2;
   localparam int RSP_DEPTH         = 2;
   localparam int NUM_LIMITS        = 4;

   typedef logic [COUNTER_WIDTH-1:0] cnt_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
      logic       frame_start;
      logic [3:0] stat_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [5:0]  header_len;
      logic [15:0] total_len;
      logic [2:0]  protocol_class;
      logic [2:0]  precedence;
      logic [2:0]  service_class;
      logic [2:0]  fragment_status;
      logic [15:0] first_byte_offset;
      logic [16:0] last_byte_offset;
      logic [31:0] count_value;
   } rsp_type;

   typedef struct packed {
      rsp_type    rec;
      logic [3:0] stat_index;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   localparam logic OP_FRAME_BYTE = 1'b0;
   localparam logic OP_STAT_READ  = 1'b1;

   localparam logic [1:0] KIND_IPV4     = 2'd0;
   localparam logic [1:0] KIND_NOT_IPV4 = 2'd1;
   localparam logic [1:0] KIND_COUNT    = 2'd2;

   localparam logic [2:0] PROTO_ICMP  = 3'd0;
   localparam logic [2:0] PROTO_IGMP  = 3'd1;
   localparam logic [2:0] PROTO_IP    = 3'd2;
   localparam logic [2:0] PROTO_TCP   = 3'd3;
   localparam logic [2:0] PROTO_UDP   = 3'd4;
   localparam logic [2:0] PROTO_IPV6  = 3'd5;
   localparam logic [2:0] PROTO_OSPF  = 3'd6;
   localparam logic [2:0] PROTO_OTHER = 3'd7;

   localparam logic [7:0] IPPROTO_ICMP = 8'h01;
   localparam logic [7:0] IPPROTO_IGMP = 8'h02;
   localparam logic [7:0] IPPROTO_IP   = 8'h04;
   localparam logic [7:0] IPPROTO_TCP  = 8'h06;
   localparam logic [7:0] IPPROTO_UDP  = 8'h11;
   localparam logic [7:0] IPPROTO_IPV6 = 8'h29;
   localparam logic [7:0] IPPROTO_OSPF = 8'h59;

   localparam logic [2:0] SVC_DELAY       = 3'd0;
   localparam logic [2:0] SVC_THROUGHPUT  = 3'd1;
   localparam logic [2:0] SVC_RELIABILITY = 3'd2;
   localparam logic [2:0] SVC_COST        = 3'd3;
   localparam logic [2:0] SVC_NORMAL      = 3'd4;
   localparam logic [2:0] SVC_OTHER       = 3'd5;

   localparam logic [3:0] TOS_DELAY       = 4'b1000;
   localparam logic [3:0] TOS_THROUGHPUT  = 4'b0100;
   localparam logic [3:0] TOS_RELIABILITY = 4'b0010;
   localparam logic [3:0] TOS_COST        = 4'b0001;
   localparam logic [3:0] TOS_NORMAL      = 4'b0000;

   localparam logic [2:0] FRAG_NO_FRAG = 3'd0;
   localparam logic [2:0] FRAG_FIRST   = 3'd1;
   localparam logic [2:0] FRAG_MIDDLE  = 3'd2;
   localparam logic [2:0] FRAG_LAST    = 3'd3;
   localparam logic [2:0] FRAG_SINGLE  = 3'd4;

   localparam logic [15:0] FRAG_DF_MASK     = 16'h4000;
   localparam logic [15:0] FRAG_MF_MASK     = 16'h2000;
   localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1FFF;
   localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;

   localparam logic [1:0] CSR_BIN_SMALL  = 2'd0;
   localparam logic [1:0] CSR_BIN_MEDIUM = 2'd1;
   localparam logic [1:0] CSR_BIN_LARGE  = 2'd2;
   localparam logic [1:0] CSR_BIN_HUGE   = 2'd3;

   localparam logic [15:0] BIN_SMALL_RESET  = 16'd159;
   localparam logic [15:0] BIN_MEDIUM_RESET = 16'd639;
   localparam logic [15:0] BIN_LARGE_RESET  = 16'd1279;
   localparam logic [15:0] BIN_HUGE_RESET   = 16'd5119;

   // frame byte positions
   localparam logic [5:0] POS_ETH_TYPE_HI = 6'd12;
   localparam logic [5:0] POS_ETH_TYPE_LO = 6'd13;
   localparam logic [5:0] POS_VER_IHL     = 6'd14;
   localparam logic [5:0] POS_TOS         = 6'd15;
   localparam logic [5:0] POS_TLEN_HI     = 6'd16;
   localparam logic [5:0] POS_TLEN_LO     = 6'd17;
   localparam logic [5:0] POS_FRAG_HI     = 6'd20;
   localparam logic [5:0] POS_FRAG_LO     = 6'd21;
   localparam logic [5:0] POS_PROTO       = 6'd23;
   localparam logic [5:0] POS_SRC_FIRST   = 6'd26;
   localparam logic [5:0] POS_SRC_LAST    = 6'd29;
   localparam logic [5:0] POS_DST_FIRST   = 6'd30;
   localparam logic [5:0] POS_DST_PRE     = 6'd32;
   localparam logic [5:0] POS_DST_LAST    = 6'd33;

   function automatic logic [2:0] proto_class(input logic [7:0] proto);
      logic [2:0] pc;
      case (proto)
         IPPROTO_ICMP: pc = PROTO_ICMP;
         IPPROTO_IGMP: pc = PROTO_IGMP;
         IPPROTO_IP:   pc = PROTO_IP;
         IPPROTO_TCP:  pc = PROTO_TCP;
         IPPROTO_UDP:  pc = PROTO_UDP;
         IPPROTO_IPV6: pc = PROTO_IPV6;
         IPPROTO_OSPF: pc = PROTO_OSPF;
         default:      pc = PROTO_OTHER;
      endcase
      return pc;
   endfunction

   function automatic logic [2:0] service_class(input logic [7:0] tos);
      logic [2:0] sc;
      case (tos[4:1])
         TOS_DELAY:       sc = SVC_DELAY;
         TOS_THROUGHPUT:  sc = SVC_THROUGHPUT;
         TOS_RELIABILITY: sc = SVC_RELIABILITY;
         TOS_COST:        sc = SVC_COST;
         TOS_NORMAL:      sc = SVC_NORMAL;
         default:         sc = SVC_OTHER;
      endcase
      return sc;
   endfunction

   function automatic logic [31:0] cnt_to_word(input cnt_type c);
      logic [63:0] w;
      w = 64'(c);
      return w[31:0];
   endfunction

endpackage

// ===== hw/rtl/ihcs_front.sv =====
// Front end: accepts request beats, tracks the frame position, captures
// IPv4 header bytes and builds one job per record. Uses ihcs_pkg.
module ihcs_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic                     full,
   input  ihcs_pkg::req_type        req_data,
   output logic                     job_push,
   output ihcs_pkg::job_type        job_data
);
   import ihcs_pkg::*;

   logic [5:0]  pos_ff, pos_in;
   logic        in_frame_ff, in_frame_in;
   logic [7:0]  eth_hi_ff, eth_hi_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [7:0]  tos_ff, tos_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [15:0] frag_ff, frag_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_ff, src_in;
   logic [23:0] dst_ff, dst_in;

   logic        accept;
   logic        live;
   logic [5:0]  pos_cur;
   logic [5:0]  hlen;
   logic [15:0] hlen_ext;
   logic [15:0] payload;
   logic [15:0] offset;
   logic [2:0]  frag_status;
   rsp_type     ipv4_rec;

   always_comb begin
      hlen     = {ihl_ff, 2'b00};
      hlen_ext = 16'(hlen);
      payload  = (tlen_ff >= hlen_ext) ? (tlen_ff - hlen_ext) : 16'd0;
      offset   = {frag_ff[12:0], 3'b000};
      if ((frag_ff & FRAG_DF_MASK) != 16'd0) begin
         frag_status = FRAG_NO_FRAG;
      end else if ((frag_ff & FRAG_MF_MASK) != 16'd0) begin
         frag_status = ((frag_ff & FRAG_OFFSET_MASK) != 16'd0) ? FRAG_MIDDLE : FRAG_FIRST;
      end else begin
         frag_status = ((frag_ff & FRAG_OFFSET_MASK) != 16'd0) ? FRAG_LAST : FRAG_SINGLE;
      end
      ipv4_rec                   = '0;
      ipv4_rec.record_kind       = KIND_IPV4;
      ipv4_rec.src_addr          = src_ff;
      ipv4_rec.dst_addr          = {dst_ff, req_data.data_byte};
      ipv4_rec.header_len        = hlen;
      ipv4_rec.total_len         = tlen_ff;
      ipv4_rec.protocol_class    = proto_class(proto_ff);
      ipv4_rec.precedence        = tos_ff[7:5];
      ipv4_rec.service_class     = service_class(tos_ff);
      ipv4_rec.fragment_status   = frag_status;
      ipv4_rec.first_byte_offset = offset;
      ipv4_rec.last_byte_offset  = 17'(offset) + 17'(payload);
   end

   always_comb begin
      accept      = push && !full;
      pos_cur     = req_data.frame_start ? 6'd0 : pos_ff;
      live        = req_data.frame_start || in_frame_ff;
      pos_in      = pos_ff;
      in_frame_in = in_frame_ff;
      eth_hi_in   = eth_hi_ff;
      ihl_in      = ihl_ff;
      tos_in      = tos_ff;
      tlen_in     = tlen_ff;
      frag_in     = frag_ff;
      proto_in    = proto_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      job_push    = 1'b0;
      job_data    = '0;
      if (accept) begin
         if (req_data.opcode == OP_STAT_READ) begin
            job_push                 = 1'b1;
            job_data.rec.record_kind = KIND_COUNT;
            job_data.stat_index      = req_data.stat_index;
         end else if (live) begin
            in_frame_in = 1'b1;
            pos_in      = pos_cur + 6'd1;
            case (pos_cur) inside
               POS_ETH_TYPE_HI:                 eth_hi_in = req_data.data_byte;
               POS_VER_IHL:                     ihl_in = req_data.data_byte[3:0];
               POS_TOS:                         tos_in = req_data.data_byte;
               POS_TLEN_HI:                     tlen_in[15:8] = req_data.data_byte;
               POS_TLEN_LO:                     tlen_in[7:0] = req_data.data_byte;
               POS_FRAG_HI:                     frag_in[15:8] = req_data.data_byte;
               POS_FRAG_LO:                     frag_in[7:0] = req_data.data_byte;
               POS_PROTO:                       proto_in = req_data.data_byte;
               [POS_SRC_FIRST:POS_SRC_LAST]:    src_in = {src_ff[23:0], req_data.data_byte};
               [POS_DST_FIRST:POS_DST_PRE]:     dst_in = {dst_ff[15:0], req_data.data_byte};
               default: ;
            endcase
            if (pos_cur == POS_ETH_TYPE_LO &&
                {eth_hi_ff, req_data.data_byte} != ETHERTYPE_IPV4) begin
               in_frame_in              = 1'b0;
               pos_in                   = pos_cur;
               job_push                 = 1'b1;
               job_data.rec.record_kind = KIND_NOT_IPV4;
            end
            if (pos_cur == POS_DST_LAST) begin
               in_frame_in  = 1'b0;
               pos_in       = pos_cur;
               job_push     = 1'b1;
               job_data.rec = ipv4_rec;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         in_frame_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         in_frame_ff <= in_frame_in;
      end
   end

   always_ff @(posedge clock) begin
      eth_hi_ff <= eth_hi_in;
      ihl_ff    <= ihl_in;
      tos_ff    <= tos_in;
      tlen_ff   <= tlen_in;
      frag_ff   <= frag_in;
      proto_ff  <= proto_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
   end

endmodule

// ===== hw/rtl/ihcs_job_fifo.sv =====
// Short job queue between front and back ends.
// Register based, JOB_DEPTH entries. Uses ihcs_pkg.
module ihcs_job_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  ihcs_pkg::job_type            push_data,
   input  logic                         pop,
   output ihcs_pkg::job_type            head,
   output ihcs_pkg::fifo_status_type    status
);
   import ihcs_pkg::*;

   localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
   localparam int CNT_W = $clog2(JOB_DEPTH + 1);

   job_type            entry_ff [JOB_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(JOB_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      status.full  = (cnt_ff == CNT_W'(JOB_DEPTH));
      status.empty = (cnt_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      head         = entry_ff[rd_ptr_ff];
      wr_ptr_in    = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in       = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/ihcs_back.sv =====
// Back end: retires one job a cycle while the result queue has room, updates the
// saturating statistics counters, answers counter reads, holds the result queue; uses ihcs_pkg.
module ihcs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  ihcs_pkg::fifo_status_type    job_status,
   input  ihcs_pkg::job_type            job_head,
   output logic                         job_pop,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [15:0]                  csr_wdata,
   output logic                         empty,
   input  logic                         pop,
   output ihcs_pkg::rsp_type            rsp_data
);
   import ihcs_pkg::*;

   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam int IDX_W = $clog2(NUM_COUNTERS);

   logic [15:0]      limit_ff [NUM_LIMITS];
   logic [15:0]      limit_in [NUM_LIMITS];
   cnt_type          cnt_ff [NUM_COUNTERS];
   cnt_type          cnt_in [NUM_COUNTERS];
   rsp_type          q_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] q_cnt_ff, q_cnt_in;

   logic                    take;
   logic                    do_pop;
   logic                    is_ipv4;
   logic [15:0]             tlen;
   logic [NUM_BINS-1:0]     bin_hit;
   logic [NUM_COUNTERS-1:0] hit;
   logic [31:0]             read_value;
   rsp_type                 result;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RSP_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      take    = !job_status.empty && (q_cnt_ff != CNT_W'(RSP_DEPTH));
      job_pop = take;
      is_ipv4 = take && (job_head.rec.record_kind == KIND_IPV4);
      tlen    = job_head.rec.total_len;
      bin_hit = '0;
      if (tlen != 16'd0) begin
         if (tlen <= limit_ff[CSR_BIN_SMALL]) begin
            bin_hit[0] = 1'b1;
         end else if (tlen <= limit_ff[CSR_BIN_MEDIUM]) begin
            bin_hit[1] = 1'b1;
         end else if (tlen <= limit_ff[CSR_BIN_LARGE]) begin
            bin_hit[2] = 1'b1;
         end else if (tlen <= limit_ff[CSR_BIN_HUGE]) begin
            bin_hit[3] = 1'b1;
         end else begin
            bin_hit[4] = 1'b1;
         end
      end
      hit = '0;
      for (int i = 0; i < NUM_PROTO_CLASSES; i++) begin
         hit[i] = is_ipv4 && (job_head.rec.protocol_class == 3'(i));
      end
      for (int b = 0; b < NUM_BINS; b++) begin
         hit[BIN_BASE + b] = is_ipv4 && bin_hit[b];
      end
      for (int i = 0; i < NUM_COUNTERS; i++) begin
         cnt_in[i] = (hit[i] && cnt_ff[i] != '1) ? cnt_ff[i] + cnt_type'(1) : cnt_ff[i];
      end
      for (int i = 0; i < NUM_LIMITS; i++) begin
         limit_in[i] = (csr_we && csr_index == 2'(i)) ? csr_wdata : limit_ff[i];
      end
   end

   always_comb begin
      if (job_head.stat_index < 4'(NUM_COUNTERS)) begin
         read_value = cnt_to_word(cnt_ff[job_head.stat_index[IDX_W-1:0]]);
      end else begin
         read_value = 32'd0;
      end
      result = job_head.rec;
      if (job_head.rec.record_kind == KIND_COUNT) begin
         result.count_value = read_value;
      end
   end

   always_comb begin
      empty     = (q_cnt_ff == '0);
      do_pop    = pop && !empty;
      rsp_data  = q_ff[rd_ptr_ff];
      wr_ptr_in = take ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      q_cnt_in  = q_cnt_ff + CNT_W'(take) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff[CSR_BIN_SMALL]  <= BIN_SMALL_RESET;
         limit_ff[CSR_BIN_MEDIUM] <= BIN_MEDIUM_RESET;
         limit_ff[CSR_BIN_LARGE]  <= BIN_LARGE_RESET;
         limit_ff[CSR_BIN_HUGE]   <= BIN_HUGE_RESET;
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            cnt_ff[i] <= '0;
         end
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         for (int i = 0; i < NUM_LIMITS; i++) begin
            limit_ff[i] <= limit_in[i];
         end
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         q_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

// ===== hw/rtl/ipv4_header_classifier_stats_core.sv =====
// Top level of the IPv4 header classifier with statistics counters.
// Depends on ihcs_pkg, ihcs_front, ihcs_job_fifo and ihcs_back.
//
//   channel   handshake          payload     beat moves
//   request   push / full        req_data    frame byte or counter read
//   result    empty / pop        rsp_data    header record or counter value
//   csr       csr_we             csr_wdata   bin limit at csr_index
//
// One request beat per cycle while full is low. A result is registered first in
// the job queue, then in the back end's result queue, before it shows.
// Reset clears frame tracking, both queues, counters and restores bin limits.
// full follows the two-entry job queue; a held-off result queue stalls only
// the back end until both queues fill.
module ipv4_header_classifier_stats_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  ihcs_pkg::req_type    req_data,
   output logic                 empty,
   input  logic                 pop,
   output ihcs_pkg::rsp_type    rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata
);
   import ihcs_pkg::*;

   logic            job_push;
   job_type         job_in;
   job_type         job_head;
   logic            job_pop;
   fifo_status_type job_status;

   assign full = job_status.full;

   ihcs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (job_status.full),
      .req_data (req_data),
      .job_push (job_push),
      .job_data (job_in)
   );

   ihcs_job_fifo u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .head      (job_head),
      .status    (job_status)
   );

   ihcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_status (job_status),
      .job_head   (job_head),
      .job_pop    (job_pop),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

`ifndef ASSERT_OFF
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_full_has_jobs: assert property (@(posedge clock) disable iff (reset)
      full |-> !job_status.empty)
      else $error("full with no queued job");

   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (push && !full && req_data.opcode == OP_STAT_READ && empty && job_status.empty)
      |-> ##2 !empty)
      else $error("counter read result missing");

   a_pop_only_taken: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !job_status.empty)
      else $error("back end took from empty job queue");
`endif

endmodule

// ===== bench/tb.sv =====
// Testbench for ipv4_header_classifier_stats_core: drives frame bytes and counter reads,
// predicts every record and counter value, and checks the results beat by beat.
// Depends on ihcs_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
   import ihcs_pkg::*;

   class ipv4_stats_scoreboard;
      rsp_type     expected_q[$];
      int unsigned errors;
      logic [5:0]  byte_pos;
      bit          in_frame;
      logic [63:0] ip_word;
      logic [63:0] addr_word;
      logic [63:0] tail_word;
      cnt_type     counts[NUM_COUNTERS];
      logic [15:0] limits[NUM_LIMITS];

      function new();
         errors    = 0;
         byte_pos  = '0;
         in_frame  = 0;
         ip_word   = '0;
         addr_word = '0;
         tail_word = '0;
         foreach (counts[i]) counts[i] = '0;
         limits[CSR_BIN_SMALL]  = BIN_SMALL_RESET;
         limits[CSR_BIN_MEDIUM] = BIN_MEDIUM_RESET;
         limits[CSR_BIN_LARGE]  = BIN_LARGE_RESET;
         limits[CSR_BIN_HUGE]   = BIN_HUGE_RESET;
      endfunction

      function void set_limit(logic [1:0] idx, logic [15:0] value);
         limits[idx] = value;
      endfunction

      function void bump(int idx);
         if (counts[idx] != '1) counts[idx] = counts[idx] + 1'b1;
      endfunction

      function rsp_type header_record();
         rsp_type     rec;
         logic [7:0]  tos;
         logic [7:0]  proto;
         logic [15:0] frag;
         logic [15:0] offset;
         logic [16:0] payload;
         int          bin;
         rec   = '0;
         tos   = ip_word[55:48];
         frag  = ip_word[15:0];
         proto = addr_word[55:48];
         rec.record_kind = KIND_IPV4;
         rec.src_addr    = addr_word[31:0];
         rec.dst_addr    = tail_word[31:0];
         rec.header_len  = {ip_word[59:56], 2'b00};
         rec.total_len   = ip_word[47:32];
         rec.precedence  = tos[7:5];
         case (proto)
            IPPROTO_ICMP: rec.protocol_class = PROTO_ICMP;
            IPPROTO_IGMP: rec.protocol_class = PROTO_IGMP;
            IPPROTO_IP:   rec.protocol_class = PROTO_IP;
            IPPROTO_TCP:  rec.protocol_class = PROTO_TCP;
            IPPROTO_UDP:  rec.protocol_class = PROTO_UDP;
            IPPROTO_IPV6: rec.protocol_class = PROTO_IPV6;
            IPPROTO_OSPF: rec.protocol_class = PROTO_OSPF;
            default:      rec.protocol_class = PROTO_OTHER;
         endcase
         case (tos[4:1])
            TOS_DELAY:       rec.service_class = SVC_DELAY;
            TOS_THROUGHPUT:  rec.service_class = SVC_THROUGHPUT;
            TOS_RELIABILITY: rec.service_class = SVC_RELIABILITY;
            TOS_COST:        rec.service_class = SVC_COST;
            TOS_NORMAL:      rec.service_class = SVC_NORMAL;
            default:         rec.service_class = SVC_OTHER;
         endcase
         if ((frag & FRAG_DF_MASK) != 0)
            rec.fragment_status = FRAG_NO_FRAG;
         else if ((frag & FRAG_MF_MASK) != 0)
            rec.fragment_status = ((frag & FRAG_OFFSET_MASK) != 0) ? FRAG_MIDDLE : FRAG_FIRST;
         else
            rec.fragment_status = ((frag & FRAG_OFFSET_MASK) != 0) ? FRAG_LAST : FRAG_SINGLE;
         offset = {frag[12:0], 3'b000};
         // payload clamps at zero when the header claims more than the total
         if (rec.total_len >= 16'(rec.header_len))
            payload = 17'(rec.total_len - 16'(rec.header_len));
         else
            payload = '0;
         rec.first_byte_offset = offset;
         rec.last_byte_offset  = 17'(offset) + payload;
         if (rec.protocol_class != PROTO_OTHER) bump(int'(rec.protocol_class));
         if (rec.total_len != 0) begin
            bin = NUM_BINS - 1;
            for (int i = NUM_LIMITS - 1; i >= 0; i--)
               if (rec.total_len <= limits[i]) bin = i;
            bump(BIN_BASE + bin);
         end
         return rec;
      endfunction

      // returns 1 when the beat takes part in the block's work
      function bit note_request(req_type req);
         rsp_type rec;
         rec = '0;
         if (req.opcode == OP_STAT_READ) begin
            rec.record_kind = KIND_COUNT;
            if (req.stat_index < NUM_COUNTERS) rec.count_value = 32'(counts[req.stat_index]);
            expected_q.push_back(rec);
            return 1;
         end
         if (req.frame_start) begin
            byte_pos = '0;
            in_frame = 1;
         end
         if (!in_frame) return 0;
         if (byte_pos == POS_ETH_TYPE_HI || byte_pos == POS_ETH_TYPE_LO ||
             (byte_pos >= POS_DST_FIRST && byte_pos <= POS_DST_LAST))
            tail_word = {tail_word[55:0], req.data_byte};
         else if (byte_pos >= POS_VER_IHL && byte_pos <= POS_FRAG_LO)
            ip_word = {ip_word[55:0], req.data_byte};
         else if (byte_pos > POS_FRAG_LO && byte_pos <= POS_SRC_LAST)
            addr_word = {addr_word[55:0], req.data_byte};
         if (byte_pos == POS_ETH_TYPE_LO && tail_word[15:0] != ETHERTYPE_IPV4) begin
            in_frame = 0;
            rec.record_kind = KIND_NOT_IPV4;
            expected_q.push_back(rec);
            return 1;
         end
         if (byte_pos == POS_DST_LAST) begin
            in_frame = 0;
            expected_q.push_back(header_record());
            return 1;
         end
         byte_pos = byte_pos + 1'b1;
         return 1;
      endfunction

      function void same_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing expected, got %h", $time, got);
            return;
         end
         want = expected_q.pop_front();
         same_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
         same_field("src_addr", want.src_addr, got.src_addr);
         same_field("dst_addr", want.dst_addr, got.dst_addr);
         same_field("header_len", 32'(want.header_len), 32'(got.header_len));
         same_field("total_len", 32'(want.total_len), 32'(got.total_len));
         same_field("protocol_class", 32'(want.protocol_class), 32'(got.protocol_class));
         same_field("precedence", 32'(want.precedence), 32'(got.precedence));
         same_field("service_class", 32'(want.service_class), 32'(got.service_class));
         same_field("fragment_status", 32'(want.fragment_status),
                    32'(got.fragment_status));
         same_field("first_byte_offset", 32'(want.first_byte_offset),
                    32'(got.first_byte_offset));
         same_field("last_byte_offset", 32'(want.last_byte_offset),
                    32'(got.last_byte_offset));
         same_field("count_value", want.count_value, got.count_value);
      endfunction
   endclass

   localparam int CYCLE_LIMIT     = 200000;
   localparam int ITEMS_PER_PHASE = 110;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        push      = 1'b0;
   logic        full;
   req_type     req_data  = '0;
   logic        empty;
   logic        pop       = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we    = 1'b0;
   logic [1:0]  csr_index = CSR_BIN_SMALL;
   logic [15:0] csr_wdata = '0;

   ipv4_stats_scoreboard sb;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_cycles    = 0;
   int          item_count     = 0;
   int          cycles         = 0;
   logic [7:0]  frame_bytes[$];
   logic [7:0]  known_protos[7] = '{IPPROTO_ICMP, IPPROTO_IGMP, IPPROTO_IP, IPPROTO_TCP,
                                    IPPROTO_UDP, IPPROTO_IPV6, IPPROTO_OSPF};

   ipv4_header_classifier_stats_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: check accepted beats, then choose pop for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) sb.check_result(rsp_data);
         if (hold_cycles > 0) begin
            pop <= 1'b0;
            hold_cycles--;
         end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic pause(int n);
      push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_beat(req_type req);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) pause(1);
      req_data <= req;
      push     <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      if (sb.note_request(req)) item_count++;
   endtask

   task automatic send_read(logic [3:0] idx);
      req_type req;
      req.opcode      = OP_STAT_READ;
      req.data_byte   = 8'($urandom);
      req.frame_start = 1'($urandom);
      req.stat_index  = idx;
      send_beat(req);
   endtask

   task automatic send_byte(logic [7:0] value, logic start);
      req_type req;
      req.opcode      = OP_FRAME_BYTE;
      req.data_byte   = value;
      req.frame_start = start;
      req.stat_index  = 4'($urandom);
      send_beat(req);
   endtask

   task automatic send_frame(int len, bit mix_reads);
      for (int i = 0; i < len; i++) begin
         if (mix_reads && $urandom_range(99) < 4) send_read(4'($urandom));
         send_byte(frame_bytes[i], i == 0);
      end
   endtask

   // 34 header bytes followed by 8 bytes of payload
   function automatic void make_frame(input logic [15:0] etype, input logic [7:0] ver_ihl,
                                      input logic [7:0] tos, input logic [15:0] tlen,
                                      input logic [15:0] frag, input logic [7:0] proto,
                                      input logic [31:0] src, input logic [31:0] dst);
      frame_bytes.delete();
      repeat (12) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(etype[15:8]);
      frame_bytes.push_back(etype[7:0]);
      frame_bytes.push_back(ver_ihl);
      frame_bytes.push_back(tos);
      frame_bytes.push_back(tlen[15:8]);
      frame_bytes.push_back(tlen[7:0]);
      repeat (2) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(frag[15:8]);
      frame_bytes.push_back(frag[7:0]);
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(proto);
      repeat (2) frame_bytes.push_back(8'($urandom));
      for (int i = 3; i >= 0; i--) frame_bytes.push_back(src[8*i +: 8]);
      for (int i = 3; i >= 0; i--) frame_bytes.push_back(dst[8*i +: 8]);
      repeat (8) frame_bytes.push_back(8'($urandom));
   endfunction

   task automatic random_frame();
      logic [15:0] etype;
      logic [15:0] tlen;
      logic [15:0] frag;
      logic [7:0]  proto;
      logic [7:0]  ver_ihl;
      int          len;
      if ($urandom_range(99) < 85) etype = ETHERTYPE_IPV4;
      else if ($urandom_range(1) == 0) etype = {ETHERTYPE_IPV4[7:0], ETHERTYPE_IPV4[15:8]};
      else etype = 16'($urandom);
      case ($urandom_range(4))
         0: tlen = 16'($urandom_range(0, 120));
         1: tlen = sb.limits[$urandom_range(3)] + 16'($urandom_range(0, 2)) - 16'd1;
         2: tlen = '0;
         3: tlen = '1;
         default: tlen = 16'($urandom);
      endcase
      case ($urandom_range(5))
         0: frag = FRAG_DF_MASK | 16'($urandom_range(0, 3));
         1: frag = FRAG_MF_MASK;
         2: frag = FRAG_MF_MASK | (16'($urandom) & FRAG_OFFSET_MASK);
         3: frag = 16'($urandom) & FRAG_OFFSET_MASK;
         4: frag = '0;
         default: frag = 16'($urandom);
      endcase
      proto = ($urandom_range(99) < 75) ? known_protos[$urandom_range(6)] : 8'($urandom);
      ver_ihl = ($urandom_range(99) < 70) ? {4'h4, 4'($urandom_range(5, 15))} : 8'($urandom);
      make_frame(etype, ver_ihl, 8'($urandom), tlen, frag, proto, $urandom, $urandom);
      if ($urandom_range(99) < 15) len = $urandom_range(1, int'(POS_DST_LAST));
      else len = int'(POS_DST_LAST) + 1 + $urandom_range(0, 8);
      send_frame(len, 1'b1);
   endtask

   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_beat(logic [1:0] idx, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_limit(idx, value);
   endtask

   task automatic write_limits(logic [15:0] l_small, logic [15:0] l_medium,
                               logic [15:0] l_large, logic [15:0] l_huge);
      drain();
      repeat (6) @(posedge clock);
      csr_beat(CSR_BIN_SMALL, l_small);
      csr_beat(CSR_BIN_MEDIUM, l_medium);
      csr_beat(CSR_BIN_LARGE, l_large);
      csr_beat(CSR_BIN_HUGE, l_huge);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(int target);
      int pick;
      while (item_count < target) begin
         pick = $urandom_range(99);
         if (pick < 75) random_frame();
         else if (pick < 90) repeat ($urandom_range(1, 4)) send_read(4'($urandom));
         else repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // stray byte before any frame, empty counters, out-of-range read
      send_byte(8'hA5, 1'b0);
      send_read(4'd0);
      send_read(4'd15);
      // byte-swapped EtherType is not IPv4; following bytes ignored
      make_frame({ETHERTYPE_IPV4[7:0], ETHERTYPE_IPV4[15:8]}, 8'h45, 8'h00, 16'd60, 16'h0000,
                 IPPROTO_UDP, 32'hC0A8_0001, 32'hC0A8_0002);
      send_frame(16, 1'b0);
      make_frame(ETHERTYPE_IPV4, 8'h45, 8'h00, 16'd40, FRAG_DF_MASK, IPPROTO_TCP,
                 32'h0000_0000, 32'hFFFF_FFFF);
      send_frame(34, 1'b0);
      // short frame, abandoned by the next start
      make_frame(ETHERTYPE_IPV4, 8'h46, 8'hE0, 16'd576, FRAG_MF_MASK, IPPROTO_ICMP,
                 $urandom, $urandom);
      send_frame(20, 1'b0);
      // version 0, zero length, header longer than total, unknown protocol
      make_frame(ETHERTYPE_IPV4, 8'h0F, 8'hFF, 16'd0, 16'hFFFF, 8'hFF,
                 32'hFFFF_FFFF, 32'h0000_0000);
      send_frame(34, 1'b0);
      make_frame(ETHERTYPE_IPV4, 8'hFF, 8'h10, 16'hFFFF, FRAG_MF_MASK | FRAG_OFFSET_MASK,
                 IPPROTO_OSPF, $urandom, $urandom);
      send_frame(42, 1'b0);
      make_frame(ETHERTYPE_IPV4, 8'h45, 8'h08, 16'd20, FRAG_OFFSET_MASK, IPPROTO_IGMP,
                 $urandom, $urandom);
      send_frame(34, 1'b0);
      send_read(4'd3);
      send_read(4'd7);
      send_read(4'd11);
      send_read(4'd12);

      // long receiver hold-off while beats keep coming
      hold_cycles = 150;
      repeat (16) send_read(4'($urandom));
      make_frame(16'h86DD, 8'h60, 8'h00, 16'd0, 16'h0000, IPPROTO_IPV6, $urandom, $urandom);
      send_frame(20, 1'b0);
      drain();

      random_phase(item_count + ITEMS_PER_PHASE);

      send_idle_pct = 50;
      write_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      random_phase(item_count + ITEMS_PER_PHASE);

      send_idle_pct  = 0;
      recv_stall_pct = 50;
      write_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(item_count + ITEMS_PER_PHASE);

      send_idle_pct  = 22;
      recv_stall_pct = 22;
      write_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      random_phase(item_count + ITEMS_PER_PHASE);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_limits(16'd100, 16'd600, 16'd1500, 16'd9000);
      random_phase(item_count + ITEMS_PER_PHASE);

      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         if (sb.expected_q.size() != 0)
            $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
